[hw/rtl/prq_pkg.sv]
// Shared types and constants for the priority ready queue.
package prq_pkg;

  localparam int unsigned PrqDepth       = 64;
  localparam int unsigned PrqPriorityTop = 63;
  localparam int unsigned IdW            = 10;
  localparam int unsigned PriW           = 6;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e             opcode;
    logic [IdW-1:0]  thread_id;
    logic [PriW-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [IdW-1:0]  chosen_id;
    logic [PriW-1:0] chosen_priority;
  } out_item_t;

  // one queued thread
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [PriW-1:0] pri;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t ent;
  } cell_cmd_t;

endpackage

[hw/rtl/prq_cell.sv]
// One slot of the sorted queue chain.
module prq_cell (
  input  logic              clk_i,
  input  prq_pkg::cell_cmd_t cmd_i,
  input  logic              occupied_i,
  input  logic              left_gt_i,
  input  prq_pkg::entry_t   left_ent_i,
  input  prq_pkg::entry_t   right_ent_i,
  output logic              gt_o,
  output prq_pkg::entry_t   ent_o
);
  import prq_pkg::*;

  entry_t ent_q, ent_d;

  // new item sorts in front of this slot (free slots always yield)
  assign gt_o  = !occupied_i || (cmd_i.ent.pri > ent_q.pri);
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.enq) begin
      if (left_gt_i) begin
        ent_d = left_ent_i;
      end else if (gt_o) begin
        ent_d = cmd_i.ent;
      end
    end else if (cmd_i.deq) begin
      ent_d = right_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

endmodule

[hw/rtl/priority_ready_queue.sv]
// Top level of the priority ready queue: cell chain, count and result register.
//
// Ready queue for a priority thread scheduler.
// Input channel (in_valid_i / in_stall_o / in_data_i): an enqueue item adds
// thread_id with priority_req (clipped to PRIORITY_TOP); a dequeue item
// removes the highest-priority entry, oldest first among equal priorities.
// Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
// result item per input item, in order. status is OK, EMPTY (dequeue with
// nothing queued, run idle) or FULL (enqueue refused, queue unchanged).
// Entries live in a chain of DEPTH cells kept sorted by priority, then by
// arrival. An enqueue opens a gap at its sorted place, each cell taking its
// left neighbor's entry; a dequeue takes cell 0 and shifts the chain left.
// Result: registered in the cycle after the item is accepted.
// Throughput: one item per cycle; the whole chain moves in one step.
// Receiver stall: the result holds in the output register and in_stall_o
// rises, so no further item is taken until the result leaves.
// Reset: clears the entry count and the output valid; the queue is empty.
// Cell contents are not reset, only slots below the count are read.
module priority_ready_queue #(
  parameter int unsigned DEPTH        = prq_pkg::PrqDepth,
  parameter int unsigned PRIORITY_TOP = prq_pkg::PrqPriorityTop
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  prq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output prq_pkg::out_item_t out_data_o
);
  import prq_pkg::*;

  localparam int unsigned CntW    = $clog2(DEPTH + 1);
  localparam int unsigned TopClip = (PRIORITY_TOP > (2**PriW - 1)) ?
                                    (2**PriW - 1) : PRIORITY_TOP;
  localparam logic [PriW-1:0] TopPri = PriW'(TopClip);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  out_item_t       out_data_q, out_data_d;

  logic            in_acc;
  logic            full, empty;
  logic [PriW-1:0] pri_sat;
  cell_cmd_t       cmd;

  logic   [DEPTH-1:0] gt;
  logic   [DEPTH-1:0] occ;
  entry_t             ent [DEPTH];

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign full    = (count_q == CntW'(DEPTH));
  assign empty   = (count_q == '0);
  assign pri_sat = (in_data_i.priority_req > TopPri) ? TopPri : in_data_i.priority_req;

  always_comb begin
    cmd.enq     = in_acc && (in_data_i.opcode == OP_ENQ) && !full;
    cmd.deq     = in_acc && (in_data_i.opcode == OP_DEQ) && !empty;
    cmd.ent.id  = in_data_i.thread_id;
    cmd.ent.pri = pri_sat;
  end

  // chain of cells, cell 0 is the head
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   left_gt;
    entry_t left_ent;
    entry_t right_ent;

    assign occ[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_ent = cmd.ent;
    end else begin : g_body
      assign left_gt  = gt[i-1];
      assign left_ent = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    prq_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (occ[i]),
      .left_gt_i   (left_gt),
      .left_ent_i  (left_ent),
      .right_ent_i (right_ent),
      .gt_o        (gt[i]),
      .ent_o       (ent[i])
    );
  end

  // result and count update
  always_comb begin
    count_d    = count_q;
    out_data_d = out_data_q;
    if (in_acc) begin
      out_data_d.status          = ST_OK;
      out_data_d.chosen_id       = '0;
      out_data_d.chosen_priority = '0;
      if (in_data_i.opcode == OP_ENQ) begin
        if (full) begin
          out_data_d.status = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          out_data_d.status = ST_EMPTY;
        end else begin
          out_data_d.chosen_id       = ent[0].id;
          out_data_d.chosen_priority = ent[0].pri;
          count_d = count_q - CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // checks
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_deq_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.opcode == OP_DEQ && !empty) |=>
      (count_q == $past(count_q) - CntW'(1)))
    else $error("dequeue did not drop the count");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (ent[0].pri >= ent[1].pri))
    else $error("head entry out of priority order");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc))
    else $error("result without accepted item");

endmodule
